// ===== src/epfp_pkg.sv =====
// shared constants, types and rounding helper for the ellipse point generator
// no dependencies; imported by every module of the block

package epfp_pkg;

	localparam int PHASE_W          = 16;
	localparam int OUT_W            = 16;
	localparam int RADIUS_W         = 16;
	localparam int CFG_IDX_W        = 8;
	localparam int TURN_W           = 32;
	localparam int XY_W             = 32;
	localparam int SAT_IN_W         = 34;
	localparam int FRAC_SHIFT       = 15;
	localparam int PHASE_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_DEPTH       = 24;

	localparam logic signed [XY_W-1:0] INV_GAIN_Q30 = 32'sd652032874;

	localparam logic signed [XY_W-1:0] ATAN_TURNS [ATAN_DEPTH] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
		32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
		32'sd652,       32'sd326,       32'sd163,       32'sd81
	};

	localparam logic signed [SAT_IN_W-1:0] ROUND_HALF = 34'sd16384;
	localparam logic signed [SAT_IN_W-1:0] SAT_HI     = 34'sd32767;
	localparam logic signed [SAT_IN_W-1:0] SAT_LO     = -34'sd32768;

	typedef logic signed [XY_W-1:0] xy_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS_HORIZONTAL = 8'd0,
		REG_RADIUS_DEPTH      = 8'd1
	} reg_idx_t;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	typedef struct packed {
		logic signed [RADIUS_W-1:0] radius_horizontal;
		logic signed [RADIUS_W-1:0] radius_depth;
	} radii_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] sin_q15;
		logic signed [OUT_W-1:0] cos_q15;
	} unit_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] horiz;
		logic signed [OUT_W-1:0] depth;
	} point_t;

	// round half up by 2^15 then clamp to the signed 16-bit range
	function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [SAT_IN_W-1:0] v);
		logic signed [SAT_IN_W-1:0] t;
		t = (v + ROUND_HALF) >>> FRAC_SHIFT;
		if (t > SAT_HI) begin
			return OUT_W'(SAT_HI);
		end else if (t < SAT_LO) begin
			return OUT_W'(SAT_LO);
		end
		return OUT_W'(t);
	endfunction

endpackage

// ===== src/epfp_cfg.sv =====
// radius configuration registers written through the config channel
// depends on epfp_pkg

module epfp_cfg
	import epfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RADIUS_W-1:0]  cfg_data,
	output radii_t               radii
);

	radii_t radii_q;

	assign cfg_ready = 1'b1;
	assign radii     = radii_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radii_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RADIUS_HORIZONTAL: begin
					radii_q.radius_horizontal <= cfg_data;
				end
				REG_RADIUS_DEPTH: begin
					radii_q.radius_depth <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== src/epfp_cordic.sv =====
// pipelined cordic: phase register, one rotation per stage, quadrant fold and q1.15 rounding
// depends on epfp_pkg

module epfp_cordic
	import epfp_pkg::*;
#(
	parameter int PHASE_BITS   = PHASE_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [PHASE_W-1:0] phase_turns,
	output logic               out_valid,
	input  logic               out_ready,
	output unit_t              unit
);

	localparam int STG = CORDIC_STEPS + 2;

	logic [STG-1:0]     vld_q;
	logic [STG-1:0]     adv;
	logic [STG-1:0]     vld_nxt;
	logic [PHASE_W-1:0] phase_s0;
	logic [TURN_W-1:0]  turn_a;
	xy_t                x_s [CORDIC_STEPS];
	xy_t                y_s [CORDIC_STEPS];
	xy_t                z_s [CORDIC_STEPS];
	quad_t              quad_s [CORDIC_STEPS];
	xy_t                cos_raw;
	xy_t                sin_raw;
	unit_t              unit_s1;

	// a stage moves when downstream takes or this stage or any later stage has a bubble
	for (genvar k = 0; k < STG; k++) begin : g_adv
		assign adv[k] = out_ready || !(&vld_q[STG-1:k]);
	end

	assign vld_nxt   = {vld_q[STG-2:0], in_valid};
	assign in_ready  = adv[0];
	assign out_valid = vld_q[STG-1];
	assign unit      = unit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < STG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_nxt[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			phase_s0 <= phase_turns;
		end
	end

	// upper phase bits fall off the top of the turn word
	assign turn_a = TURN_W'(phase_s0) << (TURN_W - PHASE_BITS);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		xy_t   xi;
		xy_t   yi;
		xy_t   zi;
		quad_t qi;
		if (i == 0) begin : g_first
			assign xi = INV_GAIN_Q30;
			assign yi = '0;
			assign zi = XY_W'(turn_a[TURN_W-3:0]);
			assign qi = quad_t'(turn_a[TURN_W-1:TURN_W-2]);
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign qi = quad_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (adv[i+1]) begin
				if (!zi[XY_W-1]) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - ATAN_TURNS[i];
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + ATAN_TURNS[i];
				end
				quad_s[i] <= qi;
			end
		end
	end

	always_comb begin
		case (quad_s[CORDIC_STEPS-1])
			QUAD_0: begin
				cos_raw = x_s[CORDIC_STEPS-1];
				sin_raw = y_s[CORDIC_STEPS-1];
			end
			QUAD_1: begin
				cos_raw = -y_s[CORDIC_STEPS-1];
				sin_raw = x_s[CORDIC_STEPS-1];
			end
			QUAD_2: begin
				cos_raw = -x_s[CORDIC_STEPS-1];
				sin_raw = -y_s[CORDIC_STEPS-1];
			end
			default: begin
				cos_raw = y_s[CORDIC_STEPS-1];
				sin_raw = -x_s[CORDIC_STEPS-1];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[STG-1]) begin
			unit_s1.sin_q15 <= round_sat(SAT_IN_W'(sin_raw));
			unit_s1.cos_q15 <= round_sat(SAT_IN_W'(cos_raw));
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(unit_s1))
		else $error("cordic result changed while stalled");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) && !out_ready |-> !in_ready)
		else $error("full pipeline accepted a transaction");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[0] |-> in_ready)
		else $error("empty input stage refused a transaction");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted transaction lost at input stage");

endmodule

// ===== src/epfp_scale.sv =====
// scales the q1.15 sine and cosine by the q8.8 radii, rounds and saturates
// depends on epfp_pkg

module epfp_scale
	import epfp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  unit_t  unit,
	input  radii_t radii,
	output logic   out_valid,
	input  logic   out_ready,
	output point_t point
);

	logic                    v_q;
	logic                    adv;
	logic signed [2*OUT_W-1:0] prod_h;
	logic signed [2*OUT_W-1:0] prod_d;
	point_t                  point_s2;

	assign adv       = !v_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = v_q;
	assign point     = point_s2;

	assign prod_h = unit.sin_q15 * radii.radius_horizontal;
	assign prod_d = unit.cos_q15 * radii.radius_depth;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			point_s2.horiz <= round_sat(SAT_IN_W'(prod_h));
			point_s2.depth <= round_sat(SAT_IN_W'(prod_d));
		end
	end

endmodule

// ===== src/ellipse_point_from_phase.sv =====
// ellipse point from phase: phase register, cordic rotation registers, rounding register
// and scale register; throughput is one transaction per cycle unless out_ready stalls
// each result carries the previous input's point
// reset clears all stage valids, both radii and the held point, so the first result is 0, 0
// depends on epfp_pkg, epfp_cfg, epfp_cordic, epfp_scale

module ellipse_point_from_phase
	import epfp_pkg::*;
#(
	parameter int PHASE_BITS   = PHASE_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [PHASE_W-1:0]      phase_turns,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] horiz_prev,
	output logic signed [OUT_W-1:0] depth_prev,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [RADIUS_W-1:0]     cfg_data
);

	radii_t radii;
	unit_t  unit;
	logic   unit_valid;
	logic   unit_ready;
	point_t pt;
	logic   pt_valid;
	logic   adv_o;
	logic   out_valid_q;
	point_t held_q;
	point_t out_q;

	epfp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.radii     (radii)
	);

	epfp_cordic #(
		.PHASE_BITS   (PHASE_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.phase_turns (phase_turns),
		.out_valid   (unit_valid),
		.out_ready   (unit_ready),
		.unit        (unit)
	);

	epfp_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (unit_valid),
		.in_ready  (unit_ready),
		.unit      (unit),
		.radii     (radii),
		.out_valid (pt_valid),
		.out_ready (adv_o),
		.point     (pt)
	);

	assign adv_o      = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign horiz_prev = out_q.horiz;
	assign depth_prev = out_q.depth;

	// the new point is held, the previously held one goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			held_q      <= '0;
		end else if (adv_o) begin
			out_valid_q <= pt_valid;
			if (pt_valid) begin
				held_q <= pt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_o && pt_valid) begin
			out_q <= held_q;
		end
	end

endmodule

// ===== verif/tb.sv =====
// testbench for ellipse_point_from_phase: a cycle-free model of the cordic and the
// radius scaling predicts each delayed point, results are checked in order
// depends on epfp_pkg and the rtl of the block

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import epfp_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int ROUND_ITEMS   = 230;
	localparam int ROUNDS        = 7;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_FIRST = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_LAST  = 8'hFF;

	logic                    clk;
	logic                    arst_n      = 1'b0;
	logic                    in_valid    = 1'b0;
	logic                    in_ready;
	logic [PHASE_W-1:0]      phase_turns = '0;
	logic                    out_valid;
	logic                    out_ready   = 1'b0;
	logic signed [OUT_W-1:0] horiz_prev;
	logic signed [OUT_W-1:0] depth_prev;
	logic                    cfg_valid   = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index   = '0;
	logic [RADIUS_W-1:0]     cfg_data    = '0;

	logic signed [RADIUS_W-1:0] radius_h = '0;
	logic signed [RADIUS_W-1:0] radius_d = '0;
	point_t held_point = '0;
	point_t pending_points[$];

	int fail_count  = 0;
	int burst_left  = 0;
	int tx_gap_max  = 0;
	int rx_stall_max = 0;
	int rx_run      = 0;
	bit rx_busy     = 1'b0;
	int hold_req    = 0;
	int hold_left   = 0;

	ellipse_point_from_phase uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.phase_turns(phase_turns),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.horiz_prev (horiz_prev),
		.depth_prev (depth_prev),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

	// round half up from 2^15 and clamp to signed 16 bits
	function automatic logic signed [OUT_W-1:0] rescale(input longint v);
		longint t;
		t = (v + 64'sd16384) >>> 15;
		if (t > 32767) begin
			return 16'sh7FFF;
		end else if (t < -32768) begin
			return 16'sh8000;
		end
		return t[OUT_W-1:0];
	endfunction

	function automatic point_t ellipse_point(input logic [PHASE_W-1:0] ph,
		input logic signed [RADIUS_W-1:0] rh, input logic signed [RADIUS_W-1:0] rd);
		logic [TURN_W-1:0] a;
		quad_t quad;
		longint x, y, z, dx, dy, c, s, sn, cs;
		point_t p;
		int i;
		a = TURN_W'(ph) << (TURN_W - PHASE_BITS_DEF);
		quad = quad_t'(a[TURN_W-1 -: 2]);
		z = longint'(a[TURN_W-3:0]);
		x = longint'(INV_GAIN_Q30);
		y = 0;
		for (i = 0; i < CORDIC_STEPS_DEF; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_TURNS[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_TURNS[i];
			end
		end
		case (quad)
			QUAD_0: begin
				c = x;
				s = y;
			end
			QUAD_1: begin
				c = -y;
				s = x;
			end
			QUAD_2: begin
				c = -x;
				s = -y;
			end
			default: begin
				c = y;
				s = -x;
			end
		endcase
		sn = longint'(rescale(s));
		cs = longint'(rescale(c));
		p.horiz = rescale(sn * longint'(rh));
		p.depth = rescale(cs * longint'(rd));
		return p;
	endfunction

	// receiver: long hold on request, otherwise its own ready/stall runs
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (rx_stall_max == 0) begin
			out_ready <= 1'b1;
		end else begin
			if (rx_run == 0) begin
				rx_busy = !rx_busy;
				rx_run = rx_busy ? $urandom_range(1, rx_stall_max) : $urandom_range(1, 12);
			end
			rx_run--;
			out_ready <= !rx_busy;
		end
	end

	always @(posedge clk) begin : check_point
		point_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result transaction: horiz %0d depth %0d",
						horiz_prev, depth_prev);
			end else begin
				want = pending_points.pop_front();
				if (horiz_prev !== want.horiz || depth_prev !== want.depth) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: horiz %0d/%0d depth %0d/%0d (expected/actual)",
							want.horiz, horiz_prev, want.depth, depth_prev);
				end
			end
		end
	end

	task automatic send_phase(input logic [PHASE_W-1:0] ph);
		@(negedge clk);
		if (burst_left == 0 && tx_gap_max > 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, tx_gap_max)) @(negedge clk);
		end
		if (burst_left == 0)
			burst_left = $urandom_range(1, 16);
		in_valid <= 1'b1;
		phase_turns <= ph;
		do @(posedge clk); while (!in_ready);
		pending_points.push_back(held_point);
		held_point = ellipse_point(ph, radius_h, radius_d);
		burst_left--;
	endtask

	// stop offering, wait for every point to come out and the pipeline to settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RADIUS_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RADIUS_HORIZONTAL: radius_h = data;
			REG_RADIUS_DEPTH: radius_d = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [RADIUS_W-1:0] pick_radius();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'h0100;
			4: return 16'hFF00;
			default: return RADIUS_W'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	function automatic logic [PHASE_W-1:0] pick_phase();
		logic [PHASE_W-1:0] ph;
		if ($urandom_range(0, 3) == 0) begin
			// just around a quadrant boundary
			ph = {2'($urandom_range(0, 3)), 14'd0};
			ph = ph + PHASE_W'($urandom_range(0, 8)) - PHASE_W'(4);
		end else begin
			ph = PHASE_W'($urandom_range(0, 16'hFFFF));
		end
		return ph;
	endfunction

	// first transaction after reset carries the cleared point
	task automatic test_first_after_reset();
		send_phase(16'h1234);
		drain();
	endtask

	task automatic test_extremes();
		logic [PHASE_W-1:0] phases[10] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
			16'h0001, 16'h2000, 16'h3FFF, 16'h6000, 16'hA000};
		write_reg(REG_RADIUS_HORIZONTAL, 16'h7FFF);
		write_reg(REG_RADIUS_DEPTH, 16'h8000);
		foreach (phases[i])
			send_phase(phases[i]);
		drain();
	endtask

	task automatic test_negative_radius();
		logic [PHASE_W-1:0] phases[5] = '{16'h4000, 16'hC000, 16'h0000, 16'h8000, 16'h1555};
		write_reg(REG_RADIUS_HORIZONTAL, 16'h8000);
		write_reg(REG_RADIUS_DEPTH, 16'hFF00);
		foreach (phases[i])
			send_phase(phases[i]);
		drain();
	endtask

	// writes to unused indexes must leave both radii alone
	task automatic test_unused_index();
		write_reg(REG_NONE_FIRST, 16'h1234);
		write_reg(REG_NONE_LAST, 16'hFFFF);
		send_phase(16'h4000);
		send_phase(16'h9000);
		drain();
	endtask

	task automatic test_random_phases();
		int r;
		int n;
		for (r = 0; r < ROUNDS; r++) begin
			write_reg(REG_RADIUS_HORIZONTAL, pick_radius());
			write_reg(REG_RADIUS_DEPTH, pick_radius());
			tx_gap_max = (r == 0) ? 0 : $urandom_range(0, 8);
			rx_stall_max = (r == 0) ? 0 : $urandom_range(0, 20);
			for (n = 0; n < ROUND_ITEMS; n++)
				send_phase(pick_phase());
			drain();
		end
	endtask

	// receiver holds off while the sender keeps going, so the input stalls
	task automatic test_backpressure();
		int n;
		write_reg(REG_RADIUS_HORIZONTAL, pick_radius());
		write_reg(REG_RADIUS_DEPTH, pick_radius());
		tx_gap_max = 0;
		rx_stall_max = 3;
		hold_req = 400;
		for (n = 0; n < 120; n++)
			send_phase(pick_phase());
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_first_after_reset();
		test_extremes();
		test_negative_radius();
		test_unused_index();
		test_backpressure();
		test_random_phases();
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
